### design/lbcc_pkg.sv
// Package for the LED blink and chase controller.
// Transfer payload types, command codes and fixed constants; no dependencies.
`default_nettype none

package lbcc_pkg;

    localparam int unsigned KIND_W     = 3;
    localparam int unsigned SEL_W      = 2;
    localparam int unsigned PERIOD_W   = 16;
    localparam int unsigned MASK_W     = 3;

    localparam logic [KIND_W-1:0] KIND_TICK        = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ON          = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OFF         = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TOGGLE      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_START_BLINK = 3'd4;
    localparam logic [KIND_W-1:0] KIND_STOP_BLINK  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_START_CHASE = 3'd6;
    localparam logic [KIND_W-1:0] KIND_STOP_CHASE  = 3'd7;

    localparam logic [SEL_W-1:0] SEL_ALL = 2'd3;

    localparam logic [PERIOD_W-1:0] CHASE_PERIOD_RST = 16'd250;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SEL_W-1:0]    led_select;
        logic [PERIOD_W-1:0] blink_half;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0] lit_mask;
        logic              chase_active;
    } t_out_item;

endpackage

`default_nettype wire

### design/lbcc_out_skid.sv
// Output register plus skid register for the result channel.
// Uses t_out_item from lbcc_pkg.
`default_nettype none

module lbcc_out_skid
    import lbcc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_item i_item,
    output logic           o_full,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_item r_out_item;
    t_out_item r_skid_item;
    logic      take;

    assign take        = r_out_valid && !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (take) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= i_push;
                end
            end else if (i_push) begin
                if (r_out_valid) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_skid_valid) begin
                r_out_item <= r_skid_item;
            end else if (i_push) begin
                r_out_item <= i_item;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_item <= i_item;
            end else begin
                r_out_item <= i_item;
            end
        end
    end

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output register is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid result not moved to output register");

    a_skid_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("result pushed into stalled output was lost");

endmodule

`default_nettype wire

### design/led_blink_and_chase_controller_unit.sv
// Top level of the LED blink and chase controller.
// Depends on lbcc_pkg and lbcc_out_skid.
//
// One command per transfer: tick, on, off, toggle, start/stop blink, start/stop
// chase. Every accepted command yields one result (lit mask and chase flag),
// registered in the output register or in the skid register. The input stalls
// only while both the output register and the skid register hold results; when
// it does not stall, the sustained rate is one item per cycle.
// chase_period is written through i_cfg_we/i_cfg_wdata and resets to 250.
`default_nettype none

module led_blink_and_chase_controller_unit
    import lbcc_pkg::*;
#(
    parameter int unsigned LED_COUNT   = 3,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [PERIOD_W-1:0] i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire t_in_item            i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output t_out_item                o_out_item
);

    localparam int unsigned IDX_W = $clog2(LED_COUNT);
    localparam int unsigned CW    = COUNT_WIDTH;
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(LED_COUNT - 1);
    localparam logic [31:0] CHASE_RST_EXT = 32'(CHASE_PERIOD_RST);
    localparam logic [CW-1:0] CHASE_CNT_RST = CHASE_RST_EXT[CW-1:0];

    logic [PERIOD_W-1:0]  r_chase_period;
    logic [LED_COUNT-1:0] r_lit, n_lit;
    logic [LED_COUNT-1:0] r_blink_en, n_blink_en;
    logic [CW-1:0]        r_blink_reload [LED_COUNT];
    logic [CW-1:0]        n_blink_reload [LED_COUNT];
    logic [CW-1:0]        r_blink_count  [LED_COUNT];
    logic [CW-1:0]        n_blink_count  [LED_COUNT];
    logic                 r_chase_en, n_chase_en;
    logic [CW-1:0]        r_chase_count, n_chase_count;
    logic [IDX_W-1:0]     r_chase_idx, n_chase_idx;

    logic                 accept;
    logic                 sel_valid;
    logic [LED_COUNT-1:0] sel_mask;
    logic [LED_COUNT-1:0] sel_one;
    logic [31:0]          blink_ext;
    logic [31:0]          chase_ext;
    logic [CW-1:0]        blink_per;
    logic [CW-1:0]        chase_per;
    logic [MASK_W-1:0]    lit_out;
    t_out_item            result;
    logic                 full;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = full;

    assign blink_ext = 32'(i_in_item.blink_half);
    assign chase_ext = 32'(r_chase_period);
    assign blink_per = blink_ext[CW-1:0];
    assign chase_per = chase_ext[CW-1:0];
    assign sel_valid = 32'(i_in_item.led_select) < LED_COUNT;

    always_comb begin
        for (int i = 0; i < LED_COUNT; i++) begin
            sel_one[i]  = 32'(i_in_item.led_select) == i;
            sel_mask[i] = (i_in_item.led_select == SEL_ALL) || sel_one[i];
        end
    end

    always_comb begin
        n_lit         = r_lit;
        n_blink_en    = r_blink_en;
        n_chase_en    = r_chase_en;
        n_chase_count = r_chase_count;
        n_chase_idx   = r_chase_idx;
        for (int i = 0; i < LED_COUNT; i++) begin
            n_blink_reload[i] = r_blink_reload[i];
            n_blink_count[i]  = r_blink_count[i];
        end
        unique case (i_in_item.kind)
            KIND_TICK: begin
                if (r_chase_en) begin
                    if (r_chase_count != '0) begin
                        n_chase_count = r_chase_count - CW'(1);
                    end else begin
                        n_chase_count = chase_per;
                        n_lit[r_chase_idx] = ~r_lit[r_chase_idx];
                        n_chase_idx = (r_chase_idx == '0) ? IDX_TOP
                                                          : r_chase_idx - IDX_W'(1);
                    end
                end
                for (int i = 0; i < LED_COUNT; i++) begin
                    if (r_blink_en[i]) begin
                        if (r_blink_count[i] != '0) begin
                            n_blink_count[i] = r_blink_count[i] - CW'(1);
                        end else begin
                            n_blink_count[i] = r_blink_reload[i];
                            n_lit[i] = ~n_lit[i];
                        end
                    end
                end
            end
            KIND_ON: begin
                n_lit = r_lit | sel_mask;
            end
            KIND_OFF: begin
                n_lit = r_lit & ~sel_mask;
            end
            KIND_TOGGLE: begin
                n_lit = r_lit ^ sel_mask;
            end
            KIND_START_BLINK: begin
                for (int i = 0; i < LED_COUNT; i++) begin
                    if (sel_valid && sel_one[i]) begin
                        n_blink_en[i]     = 1'b1;
                        n_blink_reload[i] = blink_per;
                        n_blink_count[i]  = blink_per;
                    end
                end
            end
            KIND_STOP_BLINK: begin
                for (int i = 0; i < LED_COUNT; i++) begin
                    if (sel_valid && sel_one[i]) begin
                        n_blink_en[i]     = 1'b0;
                        n_blink_reload[i] = '0;
                    end
                end
            end
            KIND_START_CHASE: begin
                n_lit      = '0;
                n_blink_en = '0;
                for (int i = 0; i < LED_COUNT; i++) begin
                    n_blink_reload[i] = '0;
                end
                n_chase_idx   = IDX_TOP;
                n_chase_count = chase_per;
                n_chase_en    = 1'b1;
            end
            KIND_STOP_CHASE: begin
                n_chase_en = 1'b0;
                n_lit      = '0;
            end
        endcase
    end

    always_comb begin
        lit_out                = '0;
        lit_out[LED_COUNT-1:0] = n_lit;
        result.lit_mask        = lit_out;
        result.chase_active    = n_chase_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chase_period <= CHASE_PERIOD_RST;
        end else if (i_cfg_we) begin
            r_chase_period <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit         <= '0;
            r_blink_en    <= '0;
            r_chase_en    <= 1'b0;
            r_chase_count <= CHASE_CNT_RST;
            r_chase_idx   <= IDX_TOP;
            for (int i = 0; i < LED_COUNT; i++) begin
                r_blink_reload[i] <= '0;
                r_blink_count[i]  <= '0;
            end
        end else if (accept) begin
            r_lit         <= n_lit;
            r_blink_en    <= n_blink_en;
            r_chase_en    <= n_chase_en;
            r_chase_count <= n_chase_count;
            r_chase_idx   <= n_chase_idx;
            for (int i = 0; i < LED_COUNT; i++) begin
                r_blink_reload[i] <= n_blink_reload[i];
                r_blink_count[i]  <= n_blink_count[i];
            end
        end
    end

    lbcc_out_skid u_out_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_item      (result),
        .o_full      (full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    a_chase_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_chase_idx) < LED_COUNT)
        else $error("chase index beyond last LED");

    a_start_chase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_item.kind == KIND_START_CHASE)
        |=> (r_chase_en && r_lit == '0 && r_blink_en == '0 && r_chase_idx == IDX_TOP))
        else $error("start chase did not reset LEDs and blink");

    a_stop_chase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_item.kind == KIND_STOP_CHASE) |=> (!r_chase_en && r_lit == '0))
        else $error("stop chase left chase enabled or LEDs lit");

endmodule

`default_nettype wire

### bench/tb_led_blink_and_chase_controller_unit.sv
`timescale 1ns / 100ps
// Testbench for led_blink_and_chase_controller_unit: a directed part, then random
// command streams over several chase periods, checked against an in-bench model.
// Depends on lbcc_pkg and the controller RTL only.

module tb_led_blink_and_chase_controller_unit;
    import lbcc_pkg::*;

    localparam int unsigned LED_CNT = 3;
    localparam logic [KIND_W-1:0] LED_OPS [3] = '{KIND_ON, KIND_OFF, KIND_TOGGLE};

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [PERIOD_W-1:0] i_cfg_wdata = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out_item;

    t_in_item  cmd_pending_q [$];
    t_out_item led_expect_q [$];
    int        err_cnt        = 0;
    int        send_idle_pct  = 26;
    int        recv_stall_pct = 59;
    logic      in_taken       = 1'b0;

    // model state
    logic [MASK_W-1:0]   led_lit;
    logic                blink_on   [LED_CNT];
    logic [PERIOD_W-1:0] blink_rel  [LED_CNT];
    logic [PERIOD_W-1:0] blink_left [LED_CNT];
    logic                chase_on;
    logic [PERIOD_W-1:0] chase_cnt;
    logic [SEL_W-1:0]    chase_pos;
    logic [PERIOD_W-1:0] chase_reload;

    led_blink_and_chase_controller_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [MASK_W-1:0] led_sel_mask(logic [SEL_W-1:0] sel);
        if (sel == SEL_ALL) return MASK_W'((1 << LED_CNT) - 1);
        if (sel < LED_CNT) return MASK_W'(1 << sel);
        return '0;
    endfunction

    function automatic t_out_item advance_led_state(t_in_item c);
        t_out_item r;
        case (c.kind)
            KIND_TICK: begin
                if (chase_on) begin
                    if (chase_cnt != 0) begin
                        chase_cnt = chase_cnt - 1'b1;
                    end else begin
                        chase_cnt = chase_reload;
                        if (chase_pos < LED_CNT) led_lit ^= MASK_W'(1 << chase_pos);
                        if (chase_pos == 0 || chase_pos >= LED_CNT)
                            chase_pos = SEL_W'(LED_CNT - 1);
                        else
                            chase_pos = chase_pos - 1'b1;
                    end
                end
                for (int i = 0; i < LED_CNT; i++) begin
                    if (blink_on[i]) begin
                        if (blink_left[i] != 0) begin
                            blink_left[i] = blink_left[i] - 1'b1;
                        end else begin
                            blink_left[i] = blink_rel[i];
                            led_lit ^= MASK_W'(1 << i);
                        end
                    end
                end
            end
            KIND_ON:     led_lit |= led_sel_mask(c.led_select);
            KIND_OFF:    led_lit &= ~led_sel_mask(c.led_select);
            KIND_TOGGLE: led_lit ^= led_sel_mask(c.led_select);
            KIND_START_BLINK: begin
                if (c.led_select < LED_CNT) begin
                    blink_on[c.led_select]   = 1'b1;
                    blink_rel[c.led_select]  = c.blink_half;
                    blink_left[c.led_select] = c.blink_half;
                end
            end
            KIND_STOP_BLINK: begin
                if (c.led_select < LED_CNT) begin
                    blink_on[c.led_select]  = 1'b0;
                    blink_rel[c.led_select] = '0;
                end
            end
            KIND_START_CHASE: begin
                led_lit = '0;
                for (int i = 0; i < LED_CNT; i++) begin
                    blink_on[i]  = 1'b0;
                    blink_rel[i] = '0;
                end
                chase_pos = SEL_W'(LED_CNT - 1);
                chase_cnt = chase_reload;
                chase_on  = 1'b1;
            end
            default: begin
                chase_on = 1'b0;
                led_lit  = '0;
            end
        endcase
        led_lit &= MASK_W'((1 << LED_CNT) - 1);
        r.lit_mask     = led_lit;
        r.chase_active = chase_on;
        return r;
    endfunction

    function automatic t_in_item cmd(logic [KIND_W-1:0] k, logic [SEL_W-1:0] s,
                                     logic [PERIOD_W-1:0] p);
        t_in_item c;
        c.kind       = k;
        c.led_select = s;
        c.blink_half = p;
        return c;
    endfunction

    function automatic logic [PERIOD_W-1:0] pick_period();
        if ($urandom_range(9) == 0) return PERIOD_W'($urandom);
        return PERIOD_W'($urandom_range(0, 4));
    endfunction

    function automatic t_in_item noise_cmd();
        return cmd(KIND_W'($urandom), SEL_W'($urandom), PERIOD_W'($urandom));
    endfunction

    function automatic t_in_item tick_or_led_op();
        if ($urandom_range(5) == 0)
            return cmd(LED_OPS[$urandom_range(0, 2)], SEL_W'($urandom), pick_period());
        return cmd(KIND_TICK, SEL_W'($urandom), pick_period());
    endfunction

    task automatic report_mismatch(string what, int unsigned exp_v, int unsigned got_v);
        $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, exp_v, got_v);
        err_cnt++;
    endtask

    // sequences of blink and chase activity with random content, plus some noise
    task automatic fill_phase(int n);
        int r;
        while (cmd_pending_q.size() < n) begin
            r = $urandom_range(99);
            if (r < 40) begin
                repeat ($urandom_range(1, 3))
                    cmd_pending_q.push_back(cmd(KIND_START_BLINK, SEL_W'($urandom),
                                                pick_period()));
                repeat ($urandom_range(4, 16)) cmd_pending_q.push_back(tick_or_led_op());
                if ($urandom_range(1) == 0)
                    cmd_pending_q.push_back(cmd(KIND_STOP_BLINK, SEL_W'($urandom),
                                                pick_period()));
            end else if (r < 75) begin
                cmd_pending_q.push_back(cmd(KIND_START_CHASE, SEL_W'($urandom),
                                            pick_period()));
                repeat ($urandom_range(5, 30)) begin
                    if ($urandom_range(9) == 0)
                        cmd_pending_q.push_back(cmd(KIND_START_BLINK, SEL_W'($urandom),
                                                    pick_period()));
                    else
                        cmd_pending_q.push_back(tick_or_led_op());
                end
                if ($urandom_range(1) == 0)
                    cmd_pending_q.push_back(cmd(KIND_STOP_CHASE, SEL_W'($urandom),
                                                pick_period()));
            end else begin
                repeat ($urandom_range(1, 4)) cmd_pending_q.push_back(noise_cmd());
            end
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (cmd_pending_q.size() != 0 || i_in_valid || led_expect_q.size() != 0);
    endtask

    // driver: command channel and result-side stall
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (cmd_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_item  <= cmd_pending_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: predicts on each accepted command, checks each accepted result
    always @(posedge i_clk) begin
        t_out_item want;
        in_taken = i_in_valid && (o_in_stall == 1'b0);
        if (!i_rst_n) begin
            led_lit      = '0;
            chase_on     = 1'b0;
            chase_reload = CHASE_PERIOD_RST;
            chase_cnt    = CHASE_PERIOD_RST;
            chase_pos    = SEL_W'(LED_CNT - 1);
            for (int i = 0; i < LED_CNT; i++) begin
                blink_on[i]   = 1'b0;
                blink_rel[i]  = '0;
                blink_left[i] = '0;
            end
            led_expect_q.delete();
        end else begin
            if (i_cfg_we) chase_reload = i_cfg_wdata;
            if (in_taken) led_expect_q.push_back(advance_led_state(i_in_item));
            if (o_out_valid == 1'b1 && !i_out_stall) begin
                if (led_expect_q.size() == 0) begin
                    report_mismatch("unexpected transfer", 0, 1);
                end else begin
                    want = led_expect_q.pop_front();
                    if (o_out_item.lit_mask !== want.lit_mask)
                        report_mismatch("lit_mask", want.lit_mask, o_out_item.lit_mask);
                    if (o_out_item.chase_active !== want.chase_active)
                        report_mismatch("chase_active", want.chase_active,
                                        o_out_item.chase_active);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("** led_blink_and_chase_controller_unit: FAILED **");
        $finish;
    end

    initial begin
        int unsigned period_set [6];
        period_set = '{0, 1, 65535, 2, 0, 3};
        period_set[4] = $urandom_range(0, 7);
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset chase period
        cmd_pending_q.push_back(cmd(KIND_ON, 2'd0, '0));
        cmd_pending_q.push_back(cmd(KIND_ON, 2'd1, '0));
        cmd_pending_q.push_back(cmd(KIND_ON, 2'd2, '1));
        cmd_pending_q.push_back(cmd(KIND_OFF, 2'd1, '0));
        cmd_pending_q.push_back(cmd(KIND_TOGGLE, SEL_ALL, '0));
        cmd_pending_q.push_back(cmd(KIND_OFF, SEL_ALL, '0));
        cmd_pending_q.push_back(cmd(KIND_ON, SEL_ALL, '0));
        cmd_pending_q.push_back(cmd(KIND_TOGGLE, 2'd0, '0));
        cmd_pending_q.push_back(cmd(KIND_START_BLINK, 2'd0, '0));
        cmd_pending_q.push_back(cmd(KIND_START_BLINK, 2'd2, '1));
        cmd_pending_q.push_back(cmd(KIND_START_BLINK, SEL_ALL, 16'd5));
        cmd_pending_q.push_back(cmd(KIND_TICK, 2'd0, '0));
        cmd_pending_q.push_back(cmd(KIND_TICK, SEL_ALL, '1));
        cmd_pending_q.push_back(cmd(KIND_STOP_BLINK, SEL_ALL, '0));
        cmd_pending_q.push_back(cmd(KIND_STOP_BLINK, 2'd0, '0));
        cmd_pending_q.push_back(cmd(KIND_TICK, 2'd0, '0));
        cmd_pending_q.push_back(cmd(KIND_START_BLINK, 2'd1, 16'd1));
        repeat (4) cmd_pending_q.push_back(cmd(KIND_TICK, 2'd0, '0));
        cmd_pending_q.push_back(cmd(KIND_START_CHASE, 2'd0, '0));
        cmd_pending_q.push_back(cmd(KIND_TICK, 2'd0, '0));
        cmd_pending_q.push_back(cmd(KIND_STOP_CHASE, 2'd0, '0));
        cmd_pending_q.push_back(cmd(KIND_TOGGLE, 2'd2, '0));
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            repeat (3) @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= PERIOD_W'(period_set[ph]);
            @(negedge i_clk);
            i_cfg_we    <= 1'b0;
            if (ph < 2) begin
                send_idle_pct  = 26;
                recv_stall_pct = 59;
            end else if (ph < 4) begin
                send_idle_pct  = 59;
                recv_stall_pct = 26;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            fill_phase(171);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("** led_blink_and_chase_controller_unit: PASSED **");
        end else begin
            $display("** led_blink_and_chase_controller_unit: FAILED **");
        end
        $finish;
    end

endmodule
